// File: hw/rtl/pose_keyframe_filter_defines.svh
// Assertion macros for the pose keyframe filter.
// Included by the RTL files that carry concurrent assertions.
`ifndef POSE_KEYFRAME_FILTER_DEFINES_SVH
`define POSE_KEYFRAME_FILTER_DEFINES_SVH
`ifndef SYNTHESIS
`define PKF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pkf implication check failed");
`define PKF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pkf next-cycle check failed");
`else
`define PKF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PKF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/pkf_pkg.sv
// Shared types, constants and helper functions for the pose keyframe filter.
// Used by pkf_isqrt and pose_keyframe_filter; depends on nothing.
package pkf_pkg;
   localparam int POS_W   = 32;
   localparam int QUAT_W  = 16;
   localparam int TTHR_W  = 31;
   localparam int RTHR_W  = 15;
   localparam int CSR_W   = 31;
   localparam int ROOT_W  = 32;
   localparam int RAD_W   = 2 * ROOT_W;

   localparam logic CSR_TRANS_THR = 1'b0;
   localparam logic CSR_ROT_THR   = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE, S_NSQ, S_NSTART, S_NWAIT, S_DIVLOAD, S_DIV, S_DIVEND, S_BRANCH,
      S_DIST, S_DOT, S_DSQ, S_SWAIT, S_CORDIC, S_ANGLE, S_MAT, S_OUT
   } state_type;

   function automatic logic [15:0] atan_q16(input logic [3:0] i);
      logic [15:0] r;
      case (i)
         4'd0:    r = 16'd51472;
         4'd1:    r = 16'd30386;
         4'd2:    r = 16'd16055;
         4'd3:    r = 16'd8150;
         4'd4:    r = 16'd4091;
         4'd5:    r = 16'd2047;
         4'd6:    r = 16'd1024;
         4'd7:    r = 16'd512;
         4'd8:    r = 16'd256;
         4'd9:    r = 16'd128;
         4'd10:   r = 16'd64;
         4'd11:   r = 16'd32;
         4'd12:   r = 16'd16;
         4'd13:   r = 16'd8;
         4'd14:   r = 16'd4;
         default: r = 16'd2;
      endcase
      return r;
   endfunction

   function automatic logic signed [QUAT_W-1:0] to_q(input logic signed [33:0] v);
      logic signed [33:0] t;
      logic signed [19:0] r;
      t = v + 34'sd8192;
      r = 20'(t >>> 14);
      if (r > 20'sd32767) begin
         return 16'sh7fff;
      end else if (r < -20'sd32768) begin
         return 16'sh8000;
      end
      return r[15:0];
   endfunction
endpackage

// File: hw/rtl/pkf_isqrt.sv
// Bit-serial integer square root, one root bit per cycle.
// Depends on pkf_pkg for the root and radicand widths.
module pkf_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pkf_pkg::RAD_W-1:0]  radicand,
   output logic                       done,
   output logic [pkf_pkg::ROOT_W-1:0] root
);
   import pkf_pkg::*;

   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [35:0]       rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              active_ff, active_in;
   logic              done_ff, done_in;
   logic [35:0]       rem_sh;
   logic [35:0]       trial;

   always_comb begin
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      rem_sh    = {rem_ff[33:0], rad_ff[RAD_W-1 -: 2]};
      trial     = {2'b00, root_ff, 2'b01};
      if (start) begin
         rad_in    = radicand;
         rem_in    = '0;
         root_in   = '0;
         cnt_in    = '0;
         active_in = 1'b1;
      end else if (active_ff) begin
         rad_in = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(ROOT_W - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// File: hw/rtl/pose_keyframe_filter.sv
// Pose keyframe filter top level: sequencer around one shared multiplier.
// Depends on pkf_pkg, pkf_isqrt and pose_keyframe_filter_defines.svh.
//
//   channel | direction | handshake           | word
//   req_    | in        | req_valid/req_ready | pose and sequence start flag
//   rsp_    | out       | rsp_valid/rsp_ready | rotation matrix and translation
//   csr_    | in        | csr_write           | threshold register write
//
// A pose holds the block from its accepting edge until the result load or its drop.
// It goes straight to the matrix when it starts a sequence or no reference exists;
// else the distance test accepts it or passes it to the angle test, which accepts or drops it;
// a zero quaternion skips the square root and the four divisions.
// Reset is synchronous and clears the reference, the thresholds and the output valid flag.
// A pending result in the output register stalls only the final load step.
`include "pose_keyframe_filter_defines.svh"
module pose_keyframe_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [pkf_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [pkf_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [pkf_pkg::POS_W-1:0]    req_pos_z,
   input  logic signed [pkf_pkg::QUAT_W-1:0]   req_quat_x,
   input  logic signed [pkf_pkg::QUAT_W-1:0]   req_quat_y,
   input  logic signed [pkf_pkg::QUAT_W-1:0]   req_quat_z,
   input  logic signed [pkf_pkg::QUAT_W-1:0]   req_quat_w,
   input  logic                                req_starts_sequence,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [pkf_pkg::QUAT_W-1:0]   rsp_r00,
   output logic signed [pkf_pkg::QUAT_W-1:0]   rsp_r01,
   output logic signed [pkf_pkg::QUAT_W-1:0]   rsp_r02,
   output logic signed [pkf_pkg::QUAT_W-1:0]   rsp_r10,
   output logic signed [pkf_pkg::QUAT_W-1:0]   rsp_r11,
   output logic signed [pkf_pkg::QUAT_W-1:0]   rsp_r12,
   output logic signed [pkf_pkg::QUAT_W-1:0]   rsp_r20,
   output logic signed [pkf_pkg::QUAT_W-1:0]   rsp_r21,
   output logic signed [pkf_pkg::QUAT_W-1:0]   rsp_r22,
   output logic signed [pkf_pkg::POS_W-1:0]    rsp_out_x,
   output logic signed [pkf_pkg::POS_W-1:0]    rsp_out_y,
   output logic signed [pkf_pkg::POS_W-1:0]    rsp_out_z,
   input  logic                                csr_write,
   input  logic                                csr_index,
   input  logic [pkf_pkg::CSR_W-1:0]           csr_data
);
   import pkf_pkg::*;

   state_type state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [1:0] comp_ff, comp_in;

   logic signed [POS_W-1:0]  p_ff[3], p_in[3];
   logic signed [QUAT_W-1:0] q_ff[4], q_in[4];
   logic                     start_ff, start_in;
   logic signed [QUAT_W-1:0] u_ff[4], u_in[4];
   logic signed [POS_W-1:0]  ref_p_ff[3], ref_p_in[3];
   logic signed [QUAT_W-1:0] ref_u_ff[4], ref_u_in[4];
   logic                     has_ref_ff, has_ref_in;
   logic [TTHR_W-1:0]        tthr_ff;
   logic [RTHR_W-1:0]        rthr_ff;

   logic [32:0]              n_ff, n_in;
   logic [ROOT_W-1:0]        len_ff, len_in;
   logic [46:0]              rem_ff, rem_in;
   logic [14:0]              quo_ff, quo_in;
   logic [63:0]              sum_ff, sum_in;
   logic signed [31:0]       dot_ff, dot_in;
   logic [28:0]              d_ff, d_in;
   logic signed [31:0]       cx_ff, cx_in, cy_ff, cy_in;
   logic signed [19:0]       cz_ff, cz_in;
   logic signed [29:0]       mat_ff[9], mat_in[9];

   logic signed [32:0]       mop_a, mop_b;
   logic signed [65:0]       prod_ff;

   logic                     sq_start, sq_done;
   logic [RAD_W-1:0]         sq_rad;
   logic [ROOT_W-1:0]        sq_root;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [QUAT_W-1:0] rm_ff[9], rm_in[9];
   logic signed [POS_W-1:0]  ro_ff[3], ro_in[3];

   logic signed [32:0]       dv[3];
   logic [32:0]              av[3];
   logic                     far_any;
   logic [1:0]               ma, mb;
   logic [15:0]              mag;
   logic [47:0]              dsr_sh;
   logic [14:0]              ucap;
   logic signed [31:0]       dfin;
   logic [31:0]              dabs;
   logic signed [31:0]       xs, ys;
   logic signed [19:0]       ang;
   logic [18:0]              ang_pos;
   logic signed [33:0]       t[9];
   logic signed [33:0]       m[9];
   logic                     uzero;
   logic                     load_out;

   pkf_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dv[i] = {p_ff[i][POS_W-1], p_ff[i]} - {ref_p_ff[i][POS_W-1], ref_p_ff[i]};
         av[i] = dv[i][32] ? 33'(-dv[i]) : 33'(dv[i]);
      end
      far_any = (av[0][32:31] != 2'b00) || (av[1][32:31] != 2'b00) ||
                (av[2][32:31] != 2'b00);
      case (cnt_ff)
         4'd0:    begin ma = 2'd0; mb = 2'd0; end
         4'd1:    begin ma = 2'd1; mb = 2'd1; end
         4'd2:    begin ma = 2'd2; mb = 2'd2; end
         4'd3:    begin ma = 2'd0; mb = 2'd1; end
         4'd4:    begin ma = 2'd0; mb = 2'd2; end
         4'd5:    begin ma = 2'd1; mb = 2'd2; end
         4'd6:    begin ma = 2'd0; mb = 2'd3; end
         4'd7:    begin ma = 2'd1; mb = 2'd3; end
         default: begin ma = 2'd2; mb = 2'd3; end
      endcase
      mop_a = '0;
      mop_b = '0;
      case (state_ff)
         S_NSQ: begin
            mop_a = {{17{q_ff[cnt_ff[1:0]][QUAT_W-1]}}, q_ff[cnt_ff[1:0]]};
            mop_b = mop_a;
         end
         S_DIST: begin
            case (cnt_ff)
               4'd0:    mop_a = {1'b0, av[0][31:0]};
               4'd1:    mop_a = {1'b0, av[1][31:0]};
               4'd2:    mop_a = {1'b0, av[2][31:0]};
               default: mop_a = {2'b00, tthr_ff};
            endcase
            mop_b = mop_a;
         end
         S_DOT: begin
            mop_a = {{17{u_ff[cnt_ff[1:0]][QUAT_W-1]}}, u_ff[cnt_ff[1:0]]};
            mop_b = {{17{ref_u_ff[cnt_ff[1:0]][QUAT_W-1]}}, ref_u_ff[cnt_ff[1:0]]};
         end
         S_DSQ: begin
            mop_a = {4'b0000, d_ff};
            mop_b = mop_a;
         end
         S_MAT: begin
            mop_a = {{17{u_ff[ma][QUAT_W-1]}}, u_ff[ma]};
            mop_b = {{17{u_ff[mb][QUAT_W-1]}}, u_ff[mb]};
         end
         default: begin
            mop_a = '0;
            mop_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      comp_in      = comp_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      start_in     = start_ff;
      u_in         = u_ff;
      ref_p_in     = ref_p_ff;
      ref_u_in     = ref_u_ff;
      has_ref_in   = has_ref_ff;
      n_in         = n_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      sum_in       = sum_ff;
      dot_in       = dot_ff;
      d_in         = d_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      mat_in       = mat_ff;
      rm_in        = rm_ff;
      ro_in        = ro_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sq_start     = 1'b0;
      sq_rad       = {1'b0, n_ff, 30'd0};
      mag          = q_ff[comp_ff][QUAT_W-1] ? 16'(-q_ff[comp_ff]) : 16'(q_ff[comp_ff]);
      dsr_sh       = {15'd0, len_ff, 1'b0} << cnt_ff;
      ucap         = (quo_ff > 15'd16384) ? 15'd16384 : quo_ff;
      dfin         = dot_ff + prod_ff[31:0];
      dabs         = dfin[31] ? 32'(-dfin) : 32'(dfin);
      xs           = cx_ff >>> cnt_ff;
      ys           = cy_ff >>> cnt_ff;
      ang          = (cz_ff + 20'sd2) >>> 2;
      ang_pos      = ang[19] ? 19'd0 : ang[18:0];
      uzero        = (u_ff[0] == '0) && (u_ff[1] == '0) && (u_ff[2] == '0) &&
                     (u_ff[3] == '0);
      load_out     = 1'b0;
      for (int i = 0; i < 9; i++) begin
         t[i] = {{4{mat_ff[i][29]}}, mat_ff[i]};
      end
      if (uzero) begin
         for (int i = 0; i < 9; i++) begin
            m[i] = (i % 4 == 0) ? 34'sd268435456 : 34'sd0;
         end
      end else begin
         m[0] = 34'sd268435456 - ((t[1] + t[2]) <<< 1);
         m[1] = (t[3] - t[8]) <<< 1;
         m[2] = (t[4] + t[7]) <<< 1;
         m[3] = (t[3] + t[8]) <<< 1;
         m[4] = 34'sd268435456 - ((t[0] + t[2]) <<< 1);
         m[5] = (t[5] - t[6]) <<< 1;
         m[6] = (t[4] - t[7]) <<< 1;
         m[7] = (t[5] + t[6]) <<< 1;
         m[8] = 34'sd268435456 - ((t[0] + t[1]) <<< 1);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               p_in     = '{req_pos_x, req_pos_y, req_pos_z};
               q_in     = '{req_quat_x, req_quat_y, req_quat_z, req_quat_w};
               start_in = req_starts_sequence;
               n_in     = '0;
               cnt_in   = '0;
               state_in = S_NSQ;
            end
         end
         S_NSQ: begin
            if (cnt_ff != 4'd0) begin
               n_in = n_ff + {1'b0, prod_ff[31:0]};
            end
            if (cnt_ff == 4'd4) begin
               state_in = S_NSTART;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_NSTART: begin
            if (n_ff == '0) begin
               u_in     = '{default: '0};
               state_in = S_BRANCH;
            end else begin
               sq_start = 1'b1;
               state_in = S_NWAIT;
            end
         end
         S_NWAIT: begin
            if (sq_done) begin
               len_in   = sq_root;
               comp_in  = '0;
               state_in = S_DIVLOAD;
            end
         end
         S_DIVLOAD: begin
            rem_in   = {1'b0, mag, 30'd0} + {15'd0, len_ff};
            quo_in   = '0;
            cnt_in   = 4'd14;
            state_in = S_DIV;
         end
         S_DIV: begin
            if ({1'b0, rem_ff} >= dsr_sh) begin
               rem_in         = 47'({1'b0, rem_ff} - dsr_sh);
               quo_in[cnt_ff] = 1'b1;
            end
            if (cnt_ff == 4'd0) begin
               state_in = S_DIVEND;
            end else begin
               cnt_in = cnt_ff - 4'd1;
            end
         end
         S_DIVEND: begin
            u_in[comp_ff] = q_ff[comp_ff][QUAT_W-1] ? 16'(-{1'b0, ucap})
                                                    : 16'({1'b0, ucap});
            if (comp_ff == 2'd3) begin
               state_in = S_BRANCH;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_DIVLOAD;
            end
         end
         S_BRANCH: begin
            cnt_in = '0;
            sum_in = '0;
            dot_in = '0;
            if (start_ff || !has_ref_ff) begin
               state_in = S_MAT;
            end else begin
               state_in = S_DIST;
            end
         end
         S_DIST: begin
            if (cnt_ff == 4'd4) begin
               cnt_in = '0;
               if (far_any || (sum_ff >= prod_ff[63:0])) begin
                  state_in = S_MAT;
               end else begin
                  state_in = S_DOT;
               end
            end else begin
               if (cnt_ff != 4'd0) begin
                  sum_in = sum_ff + prod_ff[63:0];
               end
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_DOT: begin
            if (cnt_ff == 4'd4) begin
               d_in     = (dabs > 32'd268435456) ? 29'd268435456 : dabs[28:0];
               cnt_in   = '0;
               state_in = S_DSQ;
            end else begin
               if (cnt_ff != 4'd0) begin
                  dot_in = dfin;
               end
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_DSQ: begin
            if (cnt_ff == 4'd1) begin
               sq_rad   = (64'd1 << 56) - prod_ff[63:0];
               sq_start = 1'b1;
               cx_in    = {3'b000, d_ff};
               cz_in    = '0;
               state_in = S_SWAIT;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_SWAIT: begin
            if (sq_done) begin
               cy_in    = 32'(sq_root);
               cnt_in   = '0;
               state_in = S_CORDIC;
            end
         end
         S_CORDIC: begin
            if (cy_ff > 32'sd0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + $signed({4'b0000, atan_q16(cnt_ff)});
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - $signed({4'b0000, atan_q16(cnt_ff)});
            end
            if (cnt_ff == 4'd15) begin
               state_in = S_ANGLE;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_ANGLE: begin
            cnt_in = '0;
            if (ang_pos >= {4'b0000, rthr_ff}) begin
               state_in = S_MAT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MAT: begin
            if (cnt_ff != 4'd0) begin
               mat_in[cnt_ff - 4'd1] = prod_ff[29:0];
            end
            if (cnt_ff == 4'd9) begin
               state_in = S_OUT;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               for (int i = 0; i < 9; i++) begin
                  rm_in[i] = to_q(m[i]);
               end
               ro_in      = p_ff;
               ref_p_in   = p_ff;
               ref_u_in   = u_ff;
               has_ref_in = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         comp_ff      <= '0;
         has_ref_ff   <= 1'b0;
         ref_p_ff     <= '{default: '0};
         ref_u_ff     <= '{default: '0};
         tthr_ff      <= '0;
         rthr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         comp_ff      <= comp_in;
         has_ref_ff   <= has_ref_in;
         ref_p_ff     <= ref_p_in;
         ref_u_ff     <= ref_u_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write && (csr_index == CSR_TRANS_THR)) begin
            tthr_ff <= csr_data[TTHR_W-1:0];
         end
         if (csr_write && (csr_index == CSR_ROT_THR)) begin
            rthr_ff <= csr_data[RTHR_W-1:0];
         end
      end
      p_ff     <= p_in;
      q_ff     <= q_in;
      start_ff <= start_in;
      u_ff     <= u_in;
      n_ff     <= n_in;
      len_ff   <= len_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      sum_ff   <= sum_in;
      dot_ff   <= dot_in;
      d_ff     <= d_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      mat_ff   <= mat_in;
      prod_ff  <= mop_a * mop_b;
      rm_ff    <= rm_in;
      ro_ff    <= ro_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_r00   = rm_ff[0];
   assign rsp_r01   = rm_ff[1];
   assign rsp_r02   = rm_ff[2];
   assign rsp_r10   = rm_ff[3];
   assign rsp_r11   = rm_ff[4];
   assign rsp_r12   = rm_ff[5];
   assign rsp_r20   = rm_ff[6];
   assign rsp_r21   = rm_ff[7];
   assign rsp_r22   = rm_ff[8];
   assign rsp_out_x = ro_ff[0];
   assign rsp_out_y = ro_ff[1];
   assign rsp_out_z = ro_ff[2];

   `PKF_ASSERT_IMP(a_sqrt_done_waiting, clock, reset, sq_done, (state_ff == S_NWAIT || state_ff == S_SWAIT))
   `PKF_ASSERT_NEXT(a_accept_starts_norm, clock, reset, req_valid && req_ready, state_ff == S_NSQ)
   `PKF_ASSERT_IMP(a_result_from_load, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_OUT)
   `PKF_ASSERT_NEXT(a_load_sets_reference, clock, reset, load_out, has_ref_ff && rsp_valid_ff)
endmodule
